/* rtl/assert_macros.svh */
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge.
`define KP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define KP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/kp_pkg.sv */
`timescale 1ns / 1ps

package kp_pkg;

  localparam int unsigned NUM_BUTTONS = 3;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned MS_W        = 16;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [1:0] BTN_MINUS = 2'd0;
  localparam logic [1:0] BTN_PLUS  = 2'd1;
  localparam logic [1:0] BTN_OK    = 2'd2;

  localparam logic [1:0] DISP_NONE = 2'd0;
  localparam logic [1:0] DISP_SHOW = 2'd1;
  localparam logic [1:0] DISP_DASH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 3'd4;

  localparam logic [MS_W-1:0]  DEBOUNCE_RST   = 16'd30;
  localparam logic [MS_W-1:0]  HOLD_RST       = 16'd500;
  localparam logic [MS_W-1:0]  REPEAT_RST     = 16'd50;
  localparam logic [CNT_W-1:0] RANGE_LOW_RST  = 7'd0;
  localparam logic [CNT_W-1:0] RANGE_HIGH_RST = 7'd99;

  typedef enum logic [1:0] {
    ST_LOW  = 2'd0,
    ST_HIGH = 2'd1,
    ST_HOLD = 2'd2
  } btn_state_e;

  typedef struct packed {
    logic [MS_W-1:0]  debounce_ms;
    logic [MS_W-1:0]  hold_ms;
    logic [MS_W-1:0]  repeat_ms;
    logic [CNT_W-1:0] range_low;
    logic [CNT_W-1:0] range_high;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       button;
    logic [CNT_W-1:0] count;
    logic             oor;
    logic [1:0]       disp;
    logic             brew;
    logic             capsule;
  } result_t;

endpackage

/* rtl/debounced_updown_keypad_counter.sv */
`timescale 1ns / 1ps
// Debounced up/down keypad counter with hold auto-repeat.
// Input channel (in_valid_i / in_stall_o): one timestamped sample of the
// minus, plus and ok lines per item; buttons are scanned 0, 1, 2 in turn.
// Output channel (out_valid_o / out_stall_i): one result item per input item
// carrying the scanned button, the counter, the range flag and the actions.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 debounce, 1 hold, 2 repeat, 3 range low, 4 range high); write it only
// while no item is in flight.
// Path: an accepted item enters the input register, then its result enters the
// result register, where it waits until it is taken.
// Throughput: 1 item per cycle while the output is not stalled; the whole
// debounce, hold and counter update is one combinational pass between the two registers.
// Reset: clears both stages, scan position, button states, timestamps,
// counter and redisplay flag; config registers return to their defaults.
// Stall: a stalled result holds in the output register; the input register
// still takes one more item, then in_stall_o rises until the result drains.
module debounced_updown_keypad_counter import kp_pkg::*; #(
  parameter int unsigned COUNT_MAX = 99
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [MS_W-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [TIME_W-1:0]      now_ms_i,
  input  logic [NUM_BUTTONS-1:0] raw_levels_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             scanned_button_o,
  output logic [CNT_W-1:0]       count_value_o,
  output logic                   out_of_range_o,
  output logic [1:0]             display_action_o,
  output logic                   brew_request_o,
  output logic                   capsule_reset_o
);

`include "assert_macros.svh"

  cfg_t    cfg;
  result_t res, res_q;

  logic                   in_valid_q, in_valid_d;
  logic [TIME_W-1:0]      now_q;
  logic [NUM_BUTTONS-1:0] levels_q;
  logic                   out_valid_q, out_valid_d;
  logic                   adv, in_acc;
  logic                   show_dash, out_held;

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d  = in_acc ? 1'b1 : (adv ? 1'b0 : in_valid_q);
    out_valid_d = adv ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  kp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  kp_core #(
    .COUNT_MAX (COUNT_MAX)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .now_i    (now_q),
    .levels_i (levels_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q    <= now_ms_i;
      levels_q <= raw_levels_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign scanned_button_o = res_q.button;
  assign count_value_o    = res_q.count;
  assign out_of_range_o   = res_q.oor;
  assign display_action_o = res_q.disp;
  assign brew_request_o   = res_q.brew;
  assign capsule_reset_o  = res_q.capsule;

  assign show_dash = (display_action_o == DISP_DASH);
  assign out_held  = out_valid_o && out_stall_i;

  `KP_ASSERT_IMP(a_btn_valid, out_valid_o, scanned_button_o != 2'd3, "bad button code")
  `KP_ASSERT_IMP(a_cnt_max, out_valid_o, count_value_o <= CNT_W'(COUNT_MAX), "count above max")
  `KP_ASSERT_IMP(a_dash_capsule, out_valid_o, show_dash == capsule_reset_o, "dash vs capsule")
  `KP_ASSERT_IMP(a_brew_capsule, out_valid_o, !(brew_request_o && capsule_reset_o), "brew+capsule")
  `KP_ASSERT_IMP(a_back_pressure, in_valid_q && out_held, in_stall_o, "input not held")

endmodule

/* rtl/kp_cfg.sv */
`timescale 1ns / 1ps

module kp_cfg import kp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [CFG_IDX_W-1:0] idx_i,
  input  logic [MS_W-1:0]      data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        CFG_DEBOUNCE:   cfg_d.debounce_ms = data_i;
        CFG_HOLD:       cfg_d.hold_ms     = data_i;
        CFG_REPEAT:     cfg_d.repeat_ms   = data_i;
        CFG_RANGE_LOW:  cfg_d.range_low   = data_i[CNT_W-1:0];
        CFG_RANGE_HIGH: cfg_d.range_high  = data_i[CNT_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= DEBOUNCE_RST;
      cfg_q.hold_ms     <= HOLD_RST;
      cfg_q.repeat_ms   <= REPEAT_RST;
      cfg_q.range_low   <= RANGE_LOW_RST;
      cfg_q.range_high  <= RANGE_HIGH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/kp_core.sv */
`timescale 1ns / 1ps

module kp_core import kp_pkg::*; #(
  parameter int unsigned COUNT_MAX = 99
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic [TIME_W-1:0]      now_i,
  input  logic [NUM_BUTTONS-1:0] levels_i,
  input  cfg_t                   cfg_i,
  output result_t                res_o
);

  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(COUNT_MAX);

  logic [1:0]             scan_q, scan_d;
  btn_state_e             st_q [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] raw_q;
  logic [TIME_W-1:0]      ct_q [NUM_BUTTONS];
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   redisp_q, redisp_d;

  logic [1:0]        id;
  logic              rd;
  btn_state_e        st0, st1, st2;
  logic [TIME_W-1:0] ct0, ct1, dt;
  logic              press, release_ev, tick;
  logic [CNT_W-1:0]  cnt1;
  logic [1:0]        disp;

  function automatic logic [CNT_W-1:0] step_cnt(input logic [1:0] b,
                                                 input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (b == BTN_PLUS) begin
      if (c < CNT_TOP) r = c + 1'b1;
    end else if (b == BTN_MINUS) begin
      if (c != '0) r = c - 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    id     = (scan_q >= BTN_OK) ? BTN_OK : scan_q;
    scan_d = (id == BTN_OK) ? 2'd0 : id + 2'd1;
    rd     = levels_i[id];

    st0 = (!rd && st_q[id] == ST_HOLD) ? ST_LOW : st_q[id];
    ct0 = (rd != raw_q[id]) ? now_i : ct_q[id];
    dt  = now_i - ct0;

    press      = (dt > {16'd0, cfg_i.debounce_ms}) && rd && (st0 == ST_LOW);
    release_ev = (dt > {16'd0, cfg_i.debounce_ms}) && !rd && (st0 == ST_HIGH);
    st1 = press ? ST_HIGH : (release_ev ? ST_LOW : st0);
    st2 = (st1 == ST_HIGH && dt > {16'd0, cfg_i.hold_ms}) ? ST_HOLD : st1;
    tick = (st2 == ST_HOLD) && (dt > {16'd0, cfg_i.repeat_ms});
    ct1  = tick ? now_i : ct0;

    // press: redisplay only if armed, else a counter step (none for ok)
    cnt1     = (press && !redisp_q) ? step_cnt(id, cnt_q) : cnt_q;
    redisp_d = press ? 1'b0 : redisp_q;
    disp     = DISP_NONE;
    if (press && (redisp_q || id != BTN_OK)) disp = DISP_SHOW;

    // hold tick: its display action wins
    cnt_d = cnt1;
    if (tick) begin
      if (id == BTN_OK) begin
        redisp_d = 1'b1;
        disp     = DISP_DASH;
      end else begin
        cnt_d = step_cnt(id, cnt1);
        disp  = DISP_SHOW;
      end
    end

    res_o.button  = id;
    res_o.count   = cnt_d;
    res_o.oor     = (cnt_q < cfg_i.range_low) || (cnt_q > cfg_i.range_high);
    res_o.disp    = disp;
    res_o.brew    = release_ev && (id == BTN_OK);
    res_o.capsule = tick && (id == BTN_OK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      raw_q    <= '0;
      cnt_q    <= '0;
      redisp_q <= 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        st_q[i] <= ST_LOW;
        ct_q[i] <= '0;
      end
    end else if (adv_i) begin
      scan_q    <= scan_d;
      raw_q[id] <= rd;
      st_q[id]  <= st2;
      ct_q[id]  <= ct1;
      cnt_q     <= cnt_d;
      redisp_q  <= redisp_d;
    end
  end

endmodule

/* tb/debounced_updown_keypad_counter_test.sv */
`timescale 1ns / 1ps

module debounced_updown_keypad_counter_test;
  import kp_pkg::*;

  localparam int unsigned TALLY_MAX   = 99;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_OFF    = 60;

  typedef struct packed {
    logic [TIME_W-1:0]      stamp;
    logic [NUM_BUTTONS-1:0] levels;
    logic                   pinned;
    result_t                want;
  } stim_row_t;

  localparam result_t NO_CHECK = '0;

  logic                   clk_i;
  logic                   rst_ni       = 1'b0;
  logic                   cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i    = '0;
  logic [MS_W-1:0]        cfg_data_i   = '0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_stall_o;
  logic [TIME_W-1:0]      now_ms_i     = '0;
  logic [NUM_BUTTONS-1:0] raw_levels_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i  = 1'b0;
  logic [1:0]             scanned_button_o;
  logic [CNT_W-1:0]       count_value_o;
  logic                   out_of_range_o;
  logic [1:0]             display_action_o;
  logic                   brew_request_o;
  logic                   capsule_reset_o;

  debounced_updown_keypad_counter #(
    .COUNT_MAX(TALLY_MAX)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .now_ms_i        (now_ms_i),
    .raw_levels_i    (raw_levels_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .scanned_button_o(scanned_button_o),
    .count_value_o   (count_value_o),
    .out_of_range_o  (out_of_range_o),
    .display_action_o(display_action_o),
    .brew_request_o  (brew_request_o),
    .capsule_reset_o (capsule_reset_o)
  );

  // Keypad predictor state
  cfg_t              model_cfg;
  logic [1:0]        scan_pos;
  btn_state_e        key_state [NUM_BUTTONS];
  logic              key_raw   [NUM_BUTTONS];
  logic [TIME_W-1:0] key_stamp [NUM_BUTTONS];
  logic [CNT_W-1:0]  tally;
  logic              redisplay_armed;

  result_t           pending_results [$];
  logic [TIME_W-1:0] now_cursor;
  int unsigned       tx_idle_pct  = 0;
  int unsigned       rx_stall_pct = 0;
  bit                pressure_req = 1'b0;
  int unsigned       hold_off_left = 0;
  int unsigned       cycle_count = 0;
  int unsigned       items_sent = 0;
  int unsigned       results_checked = 0;
  int unsigned       mismatches = 0;
  int unsigned       input_stalls = 0;
  int unsigned       brews_seen = 0;
  int unsigned       capsules_seen = 0;
  logic [CNT_W-1:0]  peak_count = '0;

  // Directed walk at the reset settings (debounce 30, hold 500, repeat 50)
  stim_row_t directed_rows [0:26] = '{
    '{32'd0,    3'b001, 1'b1, '{BTN_MINUS, 7'd0, 1'b0, DISP_NONE, 1'b0, 1'b0}},
    '{32'd0,    3'b010, 1'b1, '{BTN_PLUS,  7'd0, 1'b0, DISP_NONE, 1'b0, 1'b0}},
    '{32'd0,    3'b100, 1'b1, '{BTN_OK,    7'd0, 1'b0, DISP_NONE, 1'b0, 1'b0}},
    '{32'd40,   3'b001, 1'b1, '{BTN_MINUS, 7'd0, 1'b0, DISP_SHOW, 1'b0, 1'b0}},
    '{32'd40,   3'b010, 1'b1, '{BTN_PLUS,  7'd1, 1'b0, DISP_SHOW, 1'b0, 1'b0}},
    '{32'd40,   3'b100, 1'b0, NO_CHECK},
    '{32'd80,   3'b000, 1'b0, NO_CHECK},
    '{32'd80,   3'b000, 1'b0, NO_CHECK},
    '{32'd80,   3'b000, 1'b0, NO_CHECK},
    '{32'd120,  3'b000, 1'b0, NO_CHECK},
    '{32'd120,  3'b000, 1'b0, NO_CHECK},
    '{32'd120,  3'b000, 1'b1, '{BTN_OK,    7'd1, 1'b0, DISP_NONE, 1'b1, 1'b0}},
    '{32'd130,  3'b100, 1'b0, NO_CHECK},
    '{32'd130,  3'b100, 1'b0, NO_CHECK},
    '{32'd130,  3'b100, 1'b0, NO_CHECK},
    '{32'd700,  3'b110, 1'b0, NO_CHECK},
    '{32'd700,  3'b110, 1'b0, NO_CHECK},
    '{32'd700,  3'b110, 1'b1, '{BTN_OK,    7'd1, 1'b0, DISP_DASH, 1'b0, 1'b1}},
    '{32'd800,  3'b010, 1'b0, NO_CHECK},
    '{32'd800,  3'b010, 1'b0, NO_CHECK},
    '{32'd800,  3'b010, 1'b0, NO_CHECK},
    '{32'd2000, 3'b010, 1'b0, NO_CHECK},
    '{32'd2000, 3'b010, 1'b0, NO_CHECK},
    '{32'd2000, 3'b001, 1'b0, NO_CHECK},
    '{32'hFFFF_FFFF, 3'b111, 1'b0, NO_CHECK},
    '{32'hFFFF_FFFF, 3'b111, 1'b0, NO_CHECK},
    '{32'hFFFF_FFFF, 3'b111, 1'b0, NO_CHECK}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void reset_keypad();
    model_cfg = '{DEBOUNCE_RST, HOLD_RST, REPEAT_RST, RANGE_LOW_RST, RANGE_HIGH_RST};
    scan_pos = BTN_MINUS;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      key_state[i] = ST_LOW;
      key_raw[i]   = 1'b0;
      key_stamp[i] = '0;
    end
    tally = '0;
    redisplay_armed = 1'b0;
  endfunction

  function automatic void bump_tally(input logic [1:0] key);
    if (key == BTN_PLUS && tally < TALLY_MAX) tally = tally + 1'b1;
    else if (key == BTN_MINUS && tally > 0) tally = tally - 1'b1;
  endfunction

  function automatic result_t scan_keypad(input logic [TIME_W-1:0] stamp,
                                          input logic [NUM_BUTTONS-1:0] levels);
    result_t           r;
    logic [1:0]        key;
    logic              rd;
    logic [TIME_W-1:0] age;
    r = '0;
    r.oor = (tally < model_cfg.range_low) || (tally > model_cfg.range_high);
    if (scan_pos >= BTN_OK) begin
      key = BTN_OK;
      scan_pos = BTN_MINUS;
    end else begin
      key = scan_pos;
      scan_pos = scan_pos + 1'b1;
    end
    rd = levels[key];
    if (!rd && key_state[key] == ST_HOLD) key_state[key] = ST_LOW;
    if (rd != key_raw[key]) key_stamp[key] = stamp;
    age = stamp - key_stamp[key];
    if (age > model_cfg.debounce_ms) begin
      if (rd && key_state[key] == ST_LOW) begin
        key_state[key] = ST_HIGH;
        if (redisplay_armed) begin
          redisplay_armed = 1'b0;
          r.disp = DISP_SHOW;
        end else if (key != BTN_OK) begin
          bump_tally(key);
          r.disp = DISP_SHOW;
        end
      end else if (!rd && key_state[key] == ST_HIGH) begin
        key_state[key] = ST_LOW;
        if (key == BTN_OK) r.brew = 1'b1;
      end
    end
    if (key_state[key] == ST_HIGH && age > model_cfg.hold_ms) key_state[key] = ST_HOLD;
    if (key_state[key] == ST_HOLD && age > model_cfg.repeat_ms) begin
      if (key == BTN_OK) begin
        redisplay_armed = 1'b1;
        r.disp = DISP_DASH;
        r.capsule = 1'b1;
      end else begin
        bump_tally(key);
        r.disp = DISP_SHOW;
      end
      key_stamp[key] = stamp;
    end
    key_raw[key] = rd;
    r.button = key;
    r.count = tally;
    return r;
  endfunction

  // All drive tasks start and end on a falling edge
  task automatic send_item(input logic [TIME_W-1:0] stamp,
                           input logic [NUM_BUTTONS-1:0] levels,
                           input logic pinned, input result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    now_ms_i     <= stamp;
    raw_levels_i <= levels;
    do @(posedge clk_i); while (in_stall_o);
    predicted = scan_keypad(stamp, levels);
    pending_results.push_back(pinned ? want : predicted);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_DEBOUNCE:   model_cfg.debounce_ms = data;
      CFG_HOLD:       model_cfg.hold_ms     = data;
      CFG_REPEAT:     model_cfg.repeat_ms   = data;
      CFG_RANGE_LOW:  model_cfg.range_low   = data[CNT_W-1:0];
      CFG_RANGE_HIGH: model_cfg.range_high  = data[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_setup(input logic [MS_W-1:0] debounce, input logic [MS_W-1:0] hold,
                             input logic [MS_W-1:0] rep, input logic [MS_W-1:0] lo,
                             input logic [MS_W-1:0] hi);
    write_reg(CFG_DEBOUNCE, debounce);
    write_reg(CFG_HOLD, hold);
    write_reg(CFG_REPEAT, rep);
    write_reg(CFG_RANGE_LOW, lo);
    write_reg(CFG_RANGE_HIGH, hi);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly held key patterns with random timing, plus glitches and time jumps
  task automatic play_random(input int unsigned count, input int unsigned max_step);
    int unsigned            sent;
    int unsigned            run;
    logic [NUM_BUTTONS-1:0] levels;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 12) begin
        levels = NUM_BUTTONS'($urandom_range(0, 7));
        if ($urandom_range(0, 1)) now_cursor = $urandom;
        else now_cursor += $urandom_range(0, 4 * max_step);
        send_item(now_cursor, levels, 1'b0, NO_CHECK);
        sent++;
      end else begin
        if ($urandom_range(0, 1)) levels = 3'b001 << $urandom_range(0, 2);
        else levels = NUM_BUTTONS'($urandom_range(0, 7));
        run = $urandom_range(3, 60);
        while (run != 0 && sent < count) begin
          now_cursor += $urandom_range(0, max_step);
          send_item(now_cursor, levels, 1'b0, NO_CHECK);
          sent++;
          run--;
        end
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (pressure_req) begin
      hold_off_left = HOLD_OFF;
      pressure_req = 1'b0;
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_off_left != 0) begin
      out_stall_i <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("debounced_updown_keypad_counter_test failed");
      $finish;
    end
    if (rst_ni && in_valid_i && in_stall_o) input_stalls++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{scanned_button_o, count_value_o, out_of_range_o, display_action_o,
              brew_request_o, capsule_reset_o};
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: button %0d count %0d", got.button, got.count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.button !== want.button || got.count !== want.count ||
            got.oor !== want.oor || got.disp !== want.disp ||
            got.brew !== want.brew || got.capsule !== want.capsule) begin
          if (mismatches < 10)
            $display({"mismatch on result %0d (exp/got): button %0d/%0d count %0d/%0d ",
                      "oor %0d/%0d disp %0d/%0d brew %0d/%0d capsule %0d/%0d"},
                     results_checked, want.button, got.button, want.count, got.count,
                     want.oor, got.oor, want.disp, got.disp, want.brew, got.brew,
                     want.capsule, got.capsule);
          mismatches++;
        end
        if (got.brew === 1'b1) brews_seen++;
        if (got.capsule === 1'b1) capsules_seen++;
        if (got.count > peak_count) peak_count = got.count;
      end
    end
  end

  initial begin
    reset_keypad();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].stamp, directed_rows[i].levels,
                directed_rows[i].pinned, directed_rows[i].want);
    now_cursor = directed_rows[26].stamp;
    drain();

    // zero thresholds: held plus ticks every scan and saturates the counter
    apply_setup(16'd0, 16'd0, 16'd0, 16'd20, 16'd80);
    tx_idle_pct = 62;
    repeat (330) begin
      now_cursor += 1;
      send_item(now_cursor, 3'b010, 1'b0, NO_CHECK);
    end
    drain();

    // inverted range, timestamps wrap through zero
    apply_setup(16'd5, 16'd60, 16'd15, 16'd99, 16'd0);
    tx_idle_pct = 0;
    rx_stall_pct = 62;
    now_cursor = 32'hFFFF_FF00;
    play_random(150, 8);
    drain();

    apply_setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd99);
    tx_idle_pct = 38;
    rx_stall_pct = 38;
    play_random(80, 30000);
    drain();

    // long output hold-off while the sender keeps pushing
    apply_setup(16'd12, 16'd100, 16'd25, 16'd30, 16'd60);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    pressure_req = 1'b1;
    play_random(200, 10);
    drain();

    apply_setup(16'd30, 16'd500, 16'd50, 16'd1, 16'd98);
    tx_idle_pct = 38;
    rx_stall_pct = 38;
    play_random(80, 40);
    drain();

    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end
    $display("%0d items over six register settings, %0d results checked, %0d input stalls",
             items_sent, results_checked, input_stalls);
    $display("counter peak %0d, %0d brew requests, %0d capsule resets",
             peak_count, brews_seen, capsules_seen);
    if (mismatches == 0) begin
      $display("debounced_updown_keypad_counter_test passed");
    end else begin
      $display("debounced_updown_keypad_counter_test failed");
    end
    $finish;
  end

endmodule
